/* src/rattr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the RADIUS attribute walker.
package rattr_pkg;

    localparam int MAX_ATTRS        = 64;
    localparam int MAX_PACKET_BYTES = 4096;

    localparam int HDR_LEN      = 20;
    localparam int AUTH_HI_POS  = 4;
    localparam int AUTH_LO_POS  = 12;
    localparam int ATTR_MIN_LEN = 2;
    localparam int VSA_MIN_LEN  = 6;
    localparam int VID_BYTES    = 4;

    localparam logic [7:0] VSA_TYPE = 8'd26;

    localparam int POS_W   = 12;
    localparam int LEN_W   = 13;
    localparam int COUNT_W = 7;

    // Result queue between the parser and the output port.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_ATTR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_ZERO_LEN = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_LIMIT    = 3'd5
    } t_status;

    typedef enum logic [8:0] {
        PH_HDR   = 9'b000000001,
        PH_ATYPE = 9'b000000010,
        PH_ALEN  = 9'b000000100,
        PH_SKIP  = 9'b000001000,
        PH_VID   = 9'b000010000,
        PH_STYPE = 9'b000100000,
        PH_SLEN  = 9'b001000000,
        PH_SVAL  = 9'b010000000,
        PH_DRAIN = 9'b100000000
    } t_phase;

    typedef struct packed {
        t_kind         kind;
        logic [7:0]    code;
        logic [7:0]    identifier;
        logic [63:0]   auth_high;
        logic [63:0]   auth_low;
        logic [7:0]    attr_type;
        logic [31:0]   vsa_vendor;
        logic [7:0]    vsa_subtype;
        logic [11:0]   value_offset;
        logic [7:0]    value_length;
        logic [COUNT_W-1:0] attr_index;
        t_status       status;
    } t_rec;

    // Which of the two records produced by one byte go into the queue.
    typedef struct packed {
        logic first;
        logic last;
    } t_push;

endpackage

/* src/rattr_parser.sv */
`timescale 1ns / 1ps
// Byte-wise RADIUS header and attribute parser producing up to two records per byte.
module rattr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_data_byte,
    input  logic [12:0]        i_packet_length,
    output rattr_pkg::t_push   o_push,
    output rattr_pkg::t_rec    o_rec_first,
    output rattr_pkg::t_rec    o_rec_last
);
    import rattr_pkg::*;

    // Control state.
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_total, n_total;
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    t_status            r_status, n_status;

    // Payload state; every field is written before it is read within a packet.
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_ident, n_ident;
    logic [63:0] r_auth_hi, n_auth_hi;
    logic [63:0] r_auth_lo, n_auth_lo;
    logic [7:0]  r_cur_type, n_cur_type;
    logic [7:0]  r_rem, n_rem;
    logic [31:0] r_vend, n_vend;
    logic [7:0]  r_sub_type, n_sub_type;
    logic [7:0]  r_sub_rem, n_sub_rem;

    logic [LEN_W-1:0] len_clamped;
    logic [LEN_W-1:0] pos_inc;
    logic [7:0]       len_rem;
    logic [7:0]       rem_dec;
    logic             overrun;
    logic             at_limit;

    always_comb begin
        if (i_packet_length == '0) begin
            len_clamped = LEN_W'(1);
        end else if (i_packet_length > LEN_W'(MAX_PACKET_BYTES)) begin
            len_clamped = LEN_W'(MAX_PACKET_BYTES);
        end else begin
            len_clamped = i_packet_length;
        end
    end

    assign pos_inc  = {1'b0, r_pos} + LEN_W'(1);
    assign len_rem  = i_data_byte - 8'(ATTR_MIN_LEN);
    assign rem_dec  = r_rem - 8'd1;
    assign overrun  = ({2'b00, r_pos} - 14'd1 + {6'd0, i_data_byte}) > {1'b0, r_total};
    assign at_limit = r_count >= COUNT_W'(MAX_ATTRS);

    always_comb begin
        n_pos      = r_pos;
        n_total    = r_total;
        n_phase    = r_phase;
        n_count    = r_count;
        n_status   = r_status;
        n_code     = r_code;
        n_ident    = r_ident;
        n_auth_hi  = r_auth_hi;
        n_auth_lo  = r_auth_lo;
        n_cur_type = r_cur_type;
        n_rem      = r_rem;
        n_vend     = r_vend;
        n_sub_type = r_sub_type;
        n_sub_rem  = r_sub_rem;
        o_push      = '0;
        o_rec_first = '0;
        o_rec_last  = '0;

        // The first byte of a packet samples its length and restarts the walk.
        if (r_pos == '0) begin
            n_total = len_clamped;
            if (len_clamped < LEN_W'(HDR_LEN)) begin
                n_phase  = PH_DRAIN;
                n_status = ST_SHORT;
            end else begin
                n_phase = PH_HDR;
            end
        end

        case (n_phase)
            PH_HDR: begin
                if (r_pos == '0) begin
                    n_code = i_data_byte;
                end else if (r_pos == POS_W'(1)) begin
                    n_ident = i_data_byte;
                end else if (r_pos >= POS_W'(AUTH_HI_POS) && r_pos < POS_W'(AUTH_LO_POS)) begin
                    n_auth_hi = {r_auth_hi[55:0], i_data_byte};
                end else if (r_pos >= POS_W'(AUTH_LO_POS) && r_pos < POS_W'(HDR_LEN)) begin
                    n_auth_lo = {r_auth_lo[55:0], i_data_byte};
                end
                if (r_pos == POS_W'(HDR_LEN - 1)) begin
                    o_push.first           = 1'b1;
                    o_rec_first.kind       = KIND_HDR;
                    o_rec_first.code       = r_code;
                    o_rec_first.identifier = r_ident;
                    o_rec_first.auth_high  = r_auth_hi;
                    o_rec_first.auth_low   = n_auth_lo;
                    n_phase                = PH_ATYPE;
                end
            end
            PH_ATYPE: begin
                n_cur_type = i_data_byte;
                n_phase    = PH_ALEN;
            end
            PH_ALEN: begin
                if (i_data_byte < 8'(ATTR_MIN_LEN)) begin
                    if (r_status == ST_OK) begin
                        n_status = ST_ZERO_LEN;
                    end
                    n_phase = PH_DRAIN;
                end else if (overrun) begin
                    if (r_status == ST_OK) begin
                        n_status = ST_OVERRUN;
                    end
                    n_phase = PH_DRAIN;
                end else if (r_cur_type == VSA_TYPE) begin
                    n_rem = len_rem;
                    if (len_rem < 8'(VSA_MIN_LEN)) begin
                        // Too short to hold a vendor id and a sub-attribute.
                        n_phase = (len_rem != '0) ? PH_SKIP : PH_ATYPE;
                    end else begin
                        n_vend    = '0;
                        n_sub_rem = 8'(VID_BYTES);
                        n_phase   = PH_VID;
                    end
                end else if (at_limit) begin
                    if (r_status == ST_OK) begin
                        n_status = ST_LIMIT;
                    end
                    n_phase = PH_DRAIN;
                end else begin
                    n_rem                    = len_rem;
                    o_push.first             = 1'b1;
                    o_rec_first.kind         = KIND_ATTR;
                    o_rec_first.attr_type    = r_cur_type;
                    o_rec_first.value_offset = pos_inc[POS_W-1:0];
                    o_rec_first.value_length = len_rem;
                    o_rec_first.attr_index   = r_count;
                    n_count                  = r_count + COUNT_W'(1);
                    n_phase                  = (len_rem != '0) ? PH_SKIP : PH_ATYPE;
                end
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_ATYPE;
                end
            end
            PH_VID: begin
                n_vend    = {r_vend[23:0], i_data_byte};
                n_rem     = rem_dec;
                n_sub_rem = r_sub_rem - 8'd1;
                if (r_sub_rem == 8'd1) begin
                    n_phase = PH_STYPE;
                end
            end
            PH_STYPE: begin
                n_sub_type = i_data_byte;
                n_rem      = rem_dec;
                n_phase    = (rem_dec != '0) ? PH_SLEN : PH_ATYPE;
            end
            PH_SLEN: begin
                n_rem = rem_dec;
                if (i_data_byte < 8'(ATTR_MIN_LEN)
                        || {1'b0, i_data_byte} > ({1'b0, rem_dec} + 9'(ATTR_MIN_LEN))
                        || at_limit) begin
                    // A bad sub-attribute ends its vendor payload quietly.
                    n_phase = (rem_dec != '0) ? PH_SKIP : PH_ATYPE;
                end else begin
                    n_sub_rem                = len_rem;
                    o_push.first             = 1'b1;
                    o_rec_first.kind         = KIND_ATTR;
                    o_rec_first.attr_type    = VSA_TYPE;
                    o_rec_first.vsa_vendor   = r_vend;
                    o_rec_first.vsa_subtype  = r_sub_type;
                    o_rec_first.value_offset = pos_inc[POS_W-1:0];
                    o_rec_first.value_length = len_rem;
                    o_rec_first.attr_index   = r_count;
                    n_count                  = r_count + COUNT_W'(1);
                    if (len_rem != '0) begin
                        n_phase = PH_SVAL;
                    end else begin
                        n_phase = (rem_dec != '0) ? PH_STYPE : PH_ATYPE;
                    end
                end
            end
            PH_SVAL: begin
                n_rem     = rem_dec;
                n_sub_rem = r_sub_rem - 8'd1;
                if (r_sub_rem == 8'd1) begin
                    n_phase = (rem_dec != '0) ? PH_STYPE : PH_ATYPE;
                end
            end
            default: begin
            end
        endcase

        // Last byte of the packet: report and clear for the next one.
        if (pos_inc >= n_total) begin
            o_push.last           = 1'b1;
            o_rec_last.kind       = KIND_END;
            o_rec_last.attr_index = n_count;
            if (n_phase == PH_ALEN && n_status == ST_OK) begin
                o_rec_last.status = ST_TRUNC;
            end else begin
                o_rec_last.status = n_status;
            end
            n_pos    = '0;
            n_phase  = PH_HDR;
            n_count  = '0;
            n_status = ST_OK;
        end else begin
            n_pos = pos_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_total  <= '0;
            r_phase  <= PH_HDR;
            r_count  <= '0;
            r_status <= ST_OK;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_code     <= n_code;
            r_ident    <= n_ident;
            r_auth_hi  <= n_auth_hi;
            r_auth_lo  <= n_auth_lo;
            r_cur_type <= n_cur_type;
            r_rem      <= n_rem;
            r_vend     <= n_vend;
            r_sub_type <= n_sub_type;
            r_sub_rem  <= n_sub_rem;
        end
    end

endmodule

/* src/radius_attribute_walker_top.sv */
`timescale 1ns / 1ps
// Top level of the RADIUS attribute walker: parser plus a small result queue.
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------------
//  input     in         i_valid / o_stall    i_data_byte, i_packet_length
//  output    out        o_valid / i_stall    o_kind .. o_status (one record per item)
//
// The block accepts one packet byte item in every cycle while o_stall is low; the parser
// state and the four-entry result queue are both written at the edge that takes the byte.
// A byte can produce two records (header or attribute, then the packet end record), so
// o_stall rises only while the queue holds more than two records; it depends on the
// queue fill alone. A stall on the output side holds the head record steady.
// Reset is synchronous and active low; it empties the queue and rewinds the parser to
// the first byte of a packet. No clearing pass is needed.
module radius_attribute_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [12:0] i_packet_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_code,
    output logic [7:0]  o_identifier,
    output logic [63:0] o_auth_high,
    output logic [63:0] o_auth_low,
    output logic [7:0]  o_attr_type,
    output logic [31:0] o_vsa_vendor,
    output logic [7:0]  o_vsa_subtype,
    output logic [11:0] o_value_offset,
    output logic [7:0]  o_value_length,
    output logic [6:0]  o_attr_index,
    output logic [2:0]  o_status
);
    import rattr_pkg::*;

    t_push rec_push;
    t_rec  rec_first;
    t_rec  rec_last;
    logic  take;
    logic  pop;

    t_rec               r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PTR_W-1:0]   wp_last;
    t_rec               head;

    // The queue always has room for two records when a byte is taken.
    assign o_stall = r_cnt > CNT_W'(FIFO_DEPTH - 2);
    assign take    = i_valid && !o_stall;
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;

    rattr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_packet_length (i_packet_length),
        .o_push          (rec_push),
        .o_rec_first     (rec_first),
        .o_rec_last      (rec_last)
    );

    // The end record goes behind the attribute or header record of the same byte.
    assign wp_last = r_wp + PTR_W'(take && rec_push.first);

    always_comb begin
        n_wp  = r_wp + PTR_W'(take && rec_push.first) + PTR_W'(take && rec_push.last);
        n_rp  = r_rp + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(take && rec_push.first) + CNT_W'(take && rec_push.last)
                - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && rec_push.first) begin
            r_fifo[r_wp] <= rec_first;
        end
        if (take && rec_push.last) begin
            r_fifo[wp_last] <= rec_last;
        end
    end

    assign head           = r_fifo[r_rp];
    assign o_kind         = head.kind;
    assign o_code         = head.code;
    assign o_identifier   = head.identifier;
    assign o_auth_high    = head.auth_high;
    assign o_auth_low     = head.auth_low;
    assign o_attr_type    = head.attr_type;
    assign o_vsa_vendor   = head.vsa_vendor;
    assign o_vsa_subtype  = head.vsa_subtype;
    assign o_value_offset = head.value_offset;
    assign o_value_length = head.value_length;
    assign o_attr_index   = head.attr_index;
    assign o_status       = head.status;

endmodule

/* src/rattr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the RADIUS attribute walker and its bind to the top level.
module rattr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [6:0]  o_attr_index,
    input logic [2:0]  o_status
);
    import rattr_pkg::*;

    // A record held back by the receiver stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output record dropped while stalled");

    // Reset leaves the result queue empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid after reset");

    // Attribute records carry no status and a slot below the limit.
    a_attr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ATTR |->
            o_status == ST_OK && o_attr_index < 7'(MAX_ATTRS))
        else $error("attribute record with bad status or slot");

    // A short packet never reaches the attribute walk.
    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END && o_status == ST_SHORT |-> o_attr_index == '0)
        else $error("short packet reports attributes");

endmodule

bind radius_attribute_walker_top rattr_checker u_rattr_checker (.*);

/* test/radius_attribute_walker_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the RADIUS attribute walker against a record predictor.
module radius_attribute_walker_top_tb;
    import rattr_pkg::*;

    // Each side idles in about this many cycles of a hundred, except inside the quiet window.
    localparam int IDLE_PCT        = 29;
    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_ITEMS    = 140;
    // The quiet window is counted in accepted items.
    localparam int QUIET_FROM      = 250;
    localparam int QUIET_TO        = 380;
    // Records are queued when their byte is taken, so a short tail is enough.
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Ways to spoil the tail of a vendor payload.
    typedef enum int {
        SUB_CLEAN,
        SUB_BAD_LEN,
        SUB_PAST_END,
        SUB_LONE_BYTE
    } t_sub_flaw;

    // One input item: a packet byte and the length field that travels with it.
    typedef struct packed {
        logic [7:0]  data;
        logic [12:0] plen;
    } t_byte_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic [12:0] i_packet_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_code;
    logic [7:0]  o_identifier;
    logic [63:0] o_auth_high;
    logic [63:0] o_auth_low;
    logic [7:0]  o_attr_type;
    logic [31:0] o_vsa_vendor;
    logic [7:0]  o_vsa_subtype;
    logic [11:0] o_value_offset;
    logic [7:0]  o_value_length;
    logic [6:0]  o_attr_index;
    logic [2:0]  o_status;

    radius_attribute_walker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_packet_length(i_packet_length),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_code         (o_code),
        .o_identifier   (o_identifier),
        .o_auth_high    (o_auth_high),
        .o_auth_low     (o_auth_low),
        .o_attr_type    (o_attr_type),
        .o_vsa_vendor   (o_vsa_vendor),
        .o_vsa_subtype  (o_vsa_subtype),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length),
        .o_attr_index   (o_attr_index),
        .o_status       (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Byte items waiting to be driven, and records the walker is expected to produce.
    t_byte_item byte_feed[$];
    t_rec       parsed_records[$];
    // The packet under construction, in wire order.
    logic [7:0] pkt_q[$];

    int  bytes_total = 0;
    int  bytes_taken = 0;
    int  mismatches = 0;
    int  silent_cycles = 0;
    logic quiet;

    assign quiet = (bytes_taken >= QUIET_FROM) && (bytes_taken < QUIET_TO);

    // Parser state of the predictor; it mirrors the walker's view of the current packet.
    logic [12:0] byte_pos;
    logic [12:0] pkt_len;
    t_phase      phase;
    logic [7:0]  hdr_code;
    logic [7:0]  hdr_ident;
    logic [63:0] auth_hi;
    logic [63:0] auth_lo;
    logic [7:0]  cur_type;
    logic [7:0]  attr_left;
    logic [31:0] vendor_acc;
    logic [7:0]  sub_type;
    logic [7:0]  sub_left;
    logic [6:0]  attr_count;
    t_status     pkt_status;

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    task automatic clear_packet();
        byte_pos   = '0;
        pkt_len    = '0;
        phase      = PH_HDR;
        hdr_code   = '0;
        hdr_ident  = '0;
        auth_hi    = '0;
        auth_lo    = '0;
        cur_type   = '0;
        attr_left  = '0;
        vendor_acc = '0;
        sub_type   = '0;
        sub_left   = '0;
        attr_count = '0;
        pkt_status = ST_OK;
    endtask

    // The first failure of a packet sets its status; the rest of the packet is drained.
    task automatic abort_packet(input t_status why);
        if (pkt_status == ST_OK) begin
            pkt_status = why;
        end
        phase = PH_DRAIN;
    endtask

    task automatic log_attribute(input logic [7:0] atype, input logic [31:0] vid,
                                 input logic [7:0] vtype, input int offset,
                                 input logic [7:0] vlen);
        t_rec rec;
        rec              = '0;
        rec.kind         = KIND_ATTR;
        rec.attr_type    = atype;
        rec.vsa_vendor   = vid;
        rec.vsa_subtype  = vtype;
        rec.value_offset = 12'(offset);
        rec.value_length = vlen;
        rec.attr_index   = attr_count;
        parsed_records.push_back(rec);
        attr_count = attr_count + 1'b1;
    endtask

    // Advances the predicted parser by one accepted byte and queues the records it yields.
    task automatic parse_byte(input logic [7:0] b, input logic [12:0] plen);
        int   pos;
        int   eff;
        t_rec rec;
        pos = int'(byte_pos);
        // The length travels on every byte but counts only on the first one of a packet.
        if (pos == 0) begin
            eff = int'(plen);
            if (eff == 0) begin
                eff = 1;
            end
            if (eff > MAX_PACKET_BYTES) begin
                eff = MAX_PACKET_BYTES;
            end
            pkt_len = 13'(eff);
            phase   = PH_HDR;
            if (eff < HDR_LEN) begin
                pkt_status = ST_SHORT;
                phase      = PH_DRAIN;
            end
        end

        case (phase)
            PH_HDR: begin
                // Bytes 2 and 3 carry the wire length field, which the walker ignores.
                if (pos == 0) begin
                    hdr_code = b;
                end else if (pos == 1) begin
                    hdr_ident = b;
                end else if (pos >= AUTH_HI_POS && pos < AUTH_LO_POS) begin
                    auth_hi = {auth_hi[55:0], b};
                end else if (pos >= AUTH_LO_POS && pos < HDR_LEN) begin
                    auth_lo = {auth_lo[55:0], b};
                end
                if (pos == HDR_LEN - 1) begin
                    rec            = '0;
                    rec.kind       = KIND_HDR;
                    rec.code       = hdr_code;
                    rec.identifier = hdr_ident;
                    rec.auth_high  = auth_hi;
                    rec.auth_low   = auth_lo;
                    parsed_records.push_back(rec);
                    phase = PH_ATYPE;
                end
            end
            PH_ATYPE: begin
                cur_type = b;
                phase    = PH_ALEN;
            end
            PH_ALEN: begin
                if (b < ATTR_MIN_LEN) begin
                    abort_packet(ST_ZERO_LEN);
                end else if (pos - 1 + int'(b) > int'(pkt_len)) begin
                    abort_packet(ST_OVERRUN);
                end else begin
                    attr_left = b - 8'd2;
                    if (cur_type == VSA_TYPE) begin
                        // Too short to hold a vendor id and one sub-attribute: skipped.
                        if (attr_left >= VSA_MIN_LEN) begin
                            vendor_acc = '0;
                            sub_left   = 8'(VID_BYTES);
                            phase      = PH_VID;
                        end else if (attr_left != 0) begin
                            phase = PH_SKIP;
                        end else begin
                            phase = PH_ATYPE;
                        end
                    end else if (attr_count >= MAX_ATTRS) begin
                        abort_packet(ST_LIMIT);
                    end else begin
                        log_attribute(cur_type, '0, '0, pos + 1, attr_left);
                        if (attr_left != 0) begin
                            phase = PH_SKIP;
                        end else begin
                            phase = PH_ATYPE;
                        end
                    end
                end
            end
            PH_SKIP: begin
                attr_left = attr_left - 1'b1;
                if (attr_left == 0) begin
                    phase = PH_ATYPE;
                end
            end
            PH_VID: begin
                vendor_acc = {vendor_acc[23:0], b};
                attr_left  = attr_left - 1'b1;
                sub_left   = sub_left - 1'b1;
                if (sub_left == 0) begin
                    phase = PH_STYPE;
                end
            end
            PH_STYPE: begin
                sub_type  = b;
                attr_left = attr_left - 1'b1;
                if (attr_left != 0) begin
                    phase = PH_SLEN;
                end else begin
                    phase = PH_ATYPE;
                end
            end
            PH_SLEN: begin
                attr_left = attr_left - 1'b1;
                // A bad sub-attribute, or one past the slot limit, ends the payload quietly.
                if (b < ATTR_MIN_LEN || int'(b) > int'(attr_left) + 2
                        || attr_count >= MAX_ATTRS) begin
                    if (attr_left != 0) begin
                        phase = PH_SKIP;
                    end else begin
                        phase = PH_ATYPE;
                    end
                end else begin
                    sub_left = b - 8'd2;
                    log_attribute(VSA_TYPE, vendor_acc, sub_type, pos + 1, sub_left);
                    if (sub_left != 0) begin
                        phase = PH_SVAL;
                    end else if (attr_left != 0) begin
                        phase = PH_STYPE;
                    end else begin
                        phase = PH_ATYPE;
                    end
                end
            end
            PH_SVAL: begin
                attr_left = attr_left - 1'b1;
                sub_left  = sub_left - 1'b1;
                if (sub_left == 0) begin
                    if (attr_left != 0) begin
                        phase = PH_STYPE;
                    end else begin
                        phase = PH_ATYPE;
                    end
                end
            end
            default: begin
            end
        endcase

        // The last byte closes the packet; a length byte still owed means truncation.
        if (pos + 1 >= int'(pkt_len)) begin
            if (phase == PH_ALEN && pkt_status == ST_OK) begin
                pkt_status = ST_TRUNC;
            end
            rec            = '0;
            rec.kind       = KIND_END;
            rec.attr_index = attr_count;
            rec.status     = pkt_status;
            parsed_records.push_back(rec);
            clear_packet();
        end else begin
            byte_pos = 13'(pos + 1);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Packet construction
    // ---------------------------------------------------------------------------------

    function automatic logic [7:0] plain_type();
        logic [7:0] t;
        t = 8'($urandom);
        if (t == VSA_TYPE) begin
            t = t + 8'd1;
        end
        return t;
    endfunction

    // Code, identifier, wire length and authenticator, all random.
    task automatic begin_packet();
        pkt_q.delete();
        repeat (HDR_LEN) pkt_q.push_back(8'($urandom));
    endtask

    task automatic add_plain(input logic [7:0] atype, input int vlen);
        pkt_q.push_back(atype);
        pkt_q.push_back(8'(vlen + 2));
        repeat (vlen) pkt_q.push_back(8'($urandom));
    endtask

    task automatic add_short_vendor(input int plen);
        pkt_q.push_back(VSA_TYPE);
        pkt_q.push_back(8'(plen + 2));
        repeat (plen) pkt_q.push_back(8'($urandom));
    endtask

    // A vendor attribute with a number of good sub-attributes and, optionally, a bad tail.
    task automatic add_vendor(input int nsub, input t_sub_flaw flaw);
        logic [7:0] pay[$];
        int         vl;
        int         extra;
        repeat (VID_BYTES) pay.push_back(8'($urandom));
        repeat (nsub) begin
            vl = $urandom_range(0, 8);
            pay.push_back(8'($urandom));
            pay.push_back(8'(vl + 2));
            repeat (vl) pay.push_back(8'($urandom));
        end
        case (flaw)
            SUB_BAD_LEN: begin
                pay.push_back(8'($urandom));
                pay.push_back(8'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3)) pay.push_back(8'($urandom));
            end
            SUB_PAST_END: begin
                extra = $urandom_range(0, 3);
                pay.push_back(8'($urandom));
                pay.push_back(8'($urandom_range(extra + 3, extra + 20)));
                repeat (extra) pay.push_back(8'($urandom));
            end
            SUB_LONE_BYTE: begin
                pay.push_back(8'($urandom));
            end
            default: begin
            end
        endcase
        pkt_q.push_back(VSA_TYPE);
        pkt_q.push_back(8'(pay.size() + 2));
        foreach (pay[i]) pkt_q.push_back(pay[i]);
    endtask

    // Sends the packet under the given length field; the byte count follows the length
    // the walker will use, so the packet is padded with random bytes or cut to fit.
    task automatic ship_packet(input int len_field);
        int         eff;
        t_byte_item item;
        eff = len_field;
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > MAX_PACKET_BYTES) begin
            eff = MAX_PACKET_BYTES;
        end
        while (pkt_q.size() < eff) pkt_q.push_back(8'($urandom));
        for (int i = 0; i < eff; i++) begin
            item.data = pkt_q[i];
            // Later bytes carry noise in the length field; the walker must ignore it.
            if (i == 0) begin
                item.plen = 13'(len_field);
            end else begin
                item.plen = 13'($urandom_range(0, 8191));
            end
            byte_feed.push_back(item);
        end
    endtask

    task automatic add_random_attr();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 19) == 0) begin
                add_plain(plain_type(), $urandom_range(0, 253));
            end else begin
                add_plain(plain_type(), $urandom_range(0, 12));
            end
        end else if (pick < 75) begin
            add_vendor($urandom_range(0, 3), SUB_CLEAN);
        end else if (pick < 85) begin
            add_vendor($urandom_range(0, 2), t_sub_flaw'($urandom_range(1, 3)));
        end else if (pick < 93) begin
            add_short_vendor($urandom_range(0, 5));
        end else begin
            // Attribute length below the minimum.
            pkt_q.push_back(8'($urandom));
            pkt_q.push_back(8'($urandom_range(0, 1)));
        end
    endtask

    // Mostly well-formed packets with random content; some are cut short or carry a
    // random tail, and a few are plain noise.
    task automatic random_packet();
        int len_field;
        int pick;
        if ($urandom_range(0, 99) < 10) begin
            pkt_q.delete();
            ship_packet($urandom_range(0, 48));
        end else begin
            begin_packet();
            repeat ($urandom_range(0, 6)) add_random_attr();
            len_field = pkt_q.size();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                len_field = len_field - $urandom_range(1, 4);
            end else if (pick < 20) begin
                len_field = len_field + $urandom_range(1, 6);
            end
            ship_packet(len_field);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Driver: presents queued items, holds a stalled item steady and predicts on accept.
    // ---------------------------------------------------------------------------------

    always @(posedge i_clk) begin : feed_driver
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data_byte, i_packet_length);
                bytes_taken <= bytes_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (byte_feed.size() != 0
                        && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = byte_feed.pop_front();
                    i_data_byte     <= nxt.data;
                    i_packet_length <= nxt.plen;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: stalls at random and checks every accepted record against the oldest
    // predicted one.
    // ---------------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : record_monitor
        t_rec want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (parsed_records.size() == 0) begin
                    $display("%0t ns: record of kind %0d arrived, none expected, got kind %0d",
                             $time, o_kind, o_kind);
                    mismatches++;
                end else begin
                    want = parsed_records.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("code", want.code, o_code);
                    check_field("identifier", want.identifier, o_identifier);
                    check_field("auth_high", want.auth_high, o_auth_high);
                    check_field("auth_low", want.auth_low, o_auth_low);
                    check_field("attr_type", want.attr_type, o_attr_type);
                    check_field("vsa_vendor", want.vsa_vendor, o_vsa_vendor);
                    check_field("vsa_subtype", want.vsa_subtype, o_vsa_subtype);
                    check_field("value_offset", want.value_offset, o_value_offset);
                    check_field("value_length", want.value_length, o_value_length);
                    check_field("attr_index", want.attr_index, o_attr_index);
                    check_field("status", want.status, o_status);
                end
            end
            i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side ends the test.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            silent_cycles <= 0;
        end else begin
            silent_cycles <= silent_cycles + 1;
        end
        if (silent_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------------------

    initial begin : run
        int start_items;
        clear_packet();

        // A one-byte packet from a zero length field, all data bits low.
        pkt_q.delete();
        pkt_q.push_back(8'h00);
        ship_packet(0);
        // One byte short of a header.
        pkt_q.delete();
        ship_packet(HDR_LEN - 1);
        // Header only, every byte high: header and end records on the same byte.
        begin_packet();
        foreach (pkt_q[i]) pkt_q[i] = 8'hFF;
        ship_packet(pkt_q.size());
        // Extreme types; the empty attribute closes the packet.
        begin_packet();
        add_plain(8'h00, 12);
        add_plain(8'hFF, 0);
        ship_packet(pkt_q.size());
        // The type byte is the last byte of the packet.
        begin_packet();
        add_plain(plain_type(), 1);
        pkt_q.push_back(plain_type());
        ship_packet(pkt_q.size());
        // Attribute length below the minimum, followed by bytes that must be ignored.
        begin_packet();
        pkt_q.push_back(plain_type());
        pkt_q.push_back(8'h01);
        ship_packet(pkt_q.size() + 3);
        // Attribute running past the end of the packet.
        begin_packet();
        add_plain(plain_type(), 2);
        pkt_q.push_back(plain_type());
        pkt_q.push_back(8'd10);
        pkt_q.push_back(8'($urandom));
        pkt_q.push_back(8'($urandom));
        ship_packet(pkt_q.size());
        // Vendor payloads: too short, empty, clean, and each kind of bad sub-attribute.
        begin_packet();
        add_short_vendor(3);
        add_short_vendor(0);
        add_vendor(2, SUB_CLEAN);
        add_vendor(1, SUB_BAD_LEN);
        add_vendor(1, SUB_PAST_END);
        add_vendor(1, SUB_LONE_BYTE);
        ship_packet(pkt_q.size());

        start_items = byte_feed.size();
        while (byte_feed.size() - start_items < RANDOM_ITEMS) random_packet();

        // The slots fill up: the second sub-attribute of the vendor attribute finds no
        // slot and is dropped, and the next standard attribute stops the packet with the
        // limit status.
        begin_packet();
        repeat (MAX_ATTRS - 1) add_plain(plain_type(), 0);
        add_vendor(2, SUB_CLEAN);
        add_plain(plain_type(), 4);
        ship_packet(pkt_q.size());

        bytes_total = byte_feed.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != bytes_total) @(negedge i_clk);
        while (parsed_records.size() != 0) @(negedge i_clk);
        // Let any stray record surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
